// File: design/trd_pkg.sv
// Shared types, constants and helpers for the TGA run-length pixel decoder.
// Used by the top, front and back of the decoder; depends on nothing else.
package trd_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [6:0]  RUN_MASK          = 7'h7F;
    localparam logic [2:0]  PIXEL_BYTES_RESET = 3'd4;
    localparam logic [31:0] PIXEL_COUNT_RESET = 32'd1;

    // Configuration register indexes.
    localparam logic CFG_PIXEL_BYTES = 1'b0;
    localparam logic CFG_PIXEL_COUNT = 1'b1;

    // One classified stream byte as it travels from the front to the back.
    typedef struct packed {
        logic       sof;
        logic [7:0] data;
        logic       hdr_repeat;
        logic [7:0] hdr_run;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  pixel_bytes;
        logic [31:0] pixel_count;
    } t_cfg;

    // Bytes per pixel as the decoder uses them: 0 acts as 1, 5 to 7 act as 4.
    function automatic logic [2:0] f_eff_bytes(input logic [2:0] pixel_bytes);
        logic [2:0] eff;
        eff = pixel_bytes;
        if (pixel_bytes == 3'd0) begin
            eff = 3'd1;
        end else if (pixel_bytes > 3'd4) begin
            eff = 3'd4;
        end
        return eff;
    endfunction

endpackage

// File: design/tga_rle_pixel_decoder_top.sv
// TGA run-length pixel decoder, one stream byte per cycle while nothing stalls.
// An accepted byte is written into the command queue, and the back end decodes
// it from there into the output register. The back end takes one byte per cycle
// unless the output stalls, as its packet state update is combinational.
// Synchronous active-low reset clears the queue, decoder state and output valid;
// configuration resets to 4 bytes per pixel and a count of 1 pixel.
module tga_rle_pixel_decoder_top #(
    parameter int QUEUE_DEPTH = trd_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_stream_byte,
    input  logic        i_start_of_image,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_pixel_value,
    output logic [7:0]  o_repeat_count,
    output logic        o_image_done,
    output logic        o_overrun
);

    localparam int CMD_W = $bits(trd_pkg::t_cmd);
    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    trd_pkg::t_cfg r_cfg;
    trd_pkg::t_cmd front_cmd;
    trd_pkg::t_cmd queue_cmd;
    logic [CMD_W-1:0] queue_data;
    logic [LVL_W-1:0] queue_level;
    logic             queue_full;
    logic             queue_valid;
    logic             push;
    logic             pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_bytes <= trd_pkg::PIXEL_BYTES_RESET;
            r_cfg.pixel_count <= trd_pkg::PIXEL_COUNT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                trd_pkg::CFG_PIXEL_BYTES: r_cfg.pixel_bytes <= i_cfg_data[2:0];
                trd_pkg::CFG_PIXEL_COUNT: r_cfg.pixel_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    trd_front u_front (
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_stream_byte    (i_stream_byte),
        .i_start_of_image (i_start_of_image),
        .i_queue_full     (queue_full),
        .o_push           (push),
        .o_cmd            (front_cmd)
    );

    trd_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_full  (queue_full),
        .o_data  (queue_data),
        .o_level (queue_level)
    );

    assign queue_cmd = trd_pkg::t_cmd'(queue_data);

    trd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_cmd_valid    (queue_valid),
        .i_cmd          (queue_cmd),
        .o_cmd_pop      (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pixel_value  (o_pixel_value),
        .o_repeat_count (o_repeat_count),
        .o_image_done   (o_image_done),
        .o_overrun      (o_overrun)
    );

    // A clipped packet always ends the image.
    a_overrun_ends_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overrun |-> o_image_done)
        else $error("overrun without image_done");

    // Every pixel covers at least one position.
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_repeat_count != 8'd0)
        else $error("zero repeat count");

    // The queue never holds more than its depth, and stalls input when full.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (queue_level <= LVL_W'(QUEUE_DEPTH)) && (queue_full == o_in_stall))
        else $error("queue level out of range");

    // A byte taken while the queue is empty and no output pixel is held is
    // popped for decoding in the next cycle.
    a_queue_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && queue_level == '0 && !o_out_valid |=> pop)
        else $error("queued byte not decoded");

endmodule

// File: design/trd_front.sv
// Input side of the decoder: accepts stream bytes and classifies them into
// commands for the queue. Depends on trd_pkg.
module trd_front (
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic [7:0]    i_stream_byte,
    input  logic          i_start_of_image,
    input  logic          i_queue_full,
    output logic          o_push,
    output trd_pkg::t_cmd o_cmd
);

    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

    // Header fields are decoded here so the back only selects them.
    always_comb begin
        o_cmd.sof        = i_start_of_image;
        o_cmd.data       = i_stream_byte;
        o_cmd.hdr_repeat = i_stream_byte[7];
        o_cmd.hdr_run    = {1'b0, i_stream_byte[6:0] & trd_pkg::RUN_MASK} + 8'd1;
    end

endmodule

// File: design/trd_queue.sv
// Short command queue between the front and the back of the decoder.
// Generic register queue; depends on nothing but its parameters.
module trd_queue #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic                       o_valid,
    output logic                       o_full,
    output logic [WIDTH-1:0]           o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_level
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_store [DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [PW-1:0]    n_rd_ptr;
    logic [LW-1:0]    r_level;
    logic [LW-1:0]    n_level;
    logic             do_push;
    logic             do_pop;

    assign o_valid = (r_level != '0);
    assign o_full  = (r_level == LW'(DEPTH));
    assign o_data  = r_store[r_rd_ptr];
    assign o_level = r_level;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_level  = r_level;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_level = r_level + 1'b1;
        end else if (do_pop && !do_push) begin
            n_level = r_level - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_store[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: design/trd_back.sv
// Execution side of the decoder: packet state, pixel assembly, pixel
// counting with clipping, and the output register. Depends on trd_pkg.
module trd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  trd_pkg::t_cfg i_cfg,
    input  logic          i_cmd_valid,
    input  trd_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [31:0]   o_pixel_value,
    output logic [7:0]    o_repeat_count,
    output logic          o_image_done,
    output logic          o_overrun
);

    logic        r_expect_hdr;
    logic        n_expect_hdr;
    logic        r_is_repeat;
    logic        n_is_repeat;
    logic [7:0]  r_left;
    logic [7:0]  n_left;
    logic [1:0]  r_byte_idx;
    logic [1:0]  n_byte_idx;
    logic [31:0] r_assembly;
    logic [31:0] n_assembly;
    logic [31:0] r_decoded;
    logic [31:0] n_decoded;
    logic        r_finished;
    logic        n_finished;

    logic        r_out_valid;
    logic        n_out_valid;
    logic [31:0] r_out_pixel;
    logic [31:0] n_out_pixel;
    logic [7:0]  r_out_count;
    logic [7:0]  n_out_count;
    logic        r_out_done;
    logic        n_out_done;
    logic        r_out_over;
    logic        n_out_over;

    logic        fire;

    assign fire      = i_cmd_valid && (!r_out_valid || !i_out_stall);
    assign o_cmd_pop = fire;

    always_comb begin
        logic        w_expect;
        logic        w_repeat;
        logic [7:0]  w_left;
        logic [1:0]  w_idx;
        logic [31:0] w_asm;
        logic [31:0] w_dec;
        logic        w_fin;
        logic [31:0] assembled;
        logic [31:0] remaining;
        logic [7:0]  count;
        logic        over;
        logic        done;

        n_expect_hdr = r_expect_hdr;
        n_is_repeat  = r_is_repeat;
        n_left       = r_left;
        n_byte_idx   = r_byte_idx;
        n_assembly   = r_assembly;
        n_decoded    = r_decoded;
        n_finished   = r_finished;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_pixel  = r_out_pixel;
        n_out_count  = r_out_count;
        n_out_done   = r_out_done;
        n_out_over   = r_out_over;

        // Start of image clears the decoder before the byte is looked at.
        w_expect = i_cmd.sof ? 1'b1   : r_expect_hdr;
        w_repeat = i_cmd.sof ? 1'b0   : r_is_repeat;
        w_left   = i_cmd.sof ? 8'd0   : r_left;
        w_idx    = i_cmd.sof ? 2'd0   : r_byte_idx;
        w_asm    = i_cmd.sof ? 32'd0  : r_assembly;
        w_dec    = i_cmd.sof ? 32'd0  : r_decoded;
        w_fin    = i_cmd.sof ? 1'b0   : r_finished;

        assembled = w_asm | ({24'd0, i_cmd.data} << {w_idx, 3'b000});
        remaining = i_cfg.pixel_count - w_dec;
        count     = 8'd1;
        over      = 1'b0;
        done      = 1'b0;

        if (fire) begin
            n_expect_hdr = w_expect;
            n_is_repeat  = w_repeat;
            n_left       = w_left;
            n_byte_idx   = w_idx;
            n_assembly   = w_asm;
            n_decoded    = w_dec;
            n_finished   = w_fin;
            if (w_fin) begin
                // Bytes after the image are dropped.
            end else if (w_dec >= i_cfg.pixel_count) begin
                n_finished = 1'b1;
            end else if (w_expect) begin
                n_is_repeat  = i_cmd.hdr_repeat;
                n_left       = i_cmd.hdr_run;
                n_expect_hdr = 1'b0;
                n_byte_idx   = 2'd0;
                n_assembly   = 32'd0;
            end else if ({1'b0, w_idx} + 3'd1 < trd_pkg::f_eff_bytes(i_cfg.pixel_bytes)) begin
                n_byte_idx = w_idx + 2'd1;
                n_assembly = assembled;
            end else begin
                if (w_repeat) begin
                    count = w_left;
                    if ({24'd0, w_left} > remaining) begin
                        count = remaining[7:0];
                        over  = 1'b1;
                    end
                    n_left       = 8'd0;
                    n_expect_hdr = 1'b1;
                end else begin
                    n_left = w_left - 8'd1;
                    if (n_left == 8'd0) begin
                        n_expect_hdr = 1'b1;
                    end
                end
                // remaining is nonzero here, so a matching count ends the image.
                done      = ({24'd0, count} == remaining);
                n_decoded = w_dec + {24'd0, count};
                if (done) begin
                    n_finished = 1'b1;
                    if (!w_repeat && n_left != 8'd0) begin
                        over = 1'b1;
                    end
                end
                n_out_valid  = 1'b1;
                n_out_pixel  = assembled;
                n_out_count  = count;
                n_out_done   = done;
                n_out_over   = over;
                n_byte_idx   = 2'd0;
                n_assembly   = 32'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_hdr <= 1'b1;
            r_is_repeat  <= 1'b0;
            r_left       <= 8'd0;
            r_byte_idx   <= 2'd0;
            r_assembly   <= 32'd0;
            r_decoded    <= 32'd0;
            r_finished   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_expect_hdr <= n_expect_hdr;
            r_is_repeat  <= n_is_repeat;
            r_left       <= n_left;
            r_byte_idx   <= n_byte_idx;
            r_assembly   <= n_assembly;
            r_decoded    <= n_decoded;
            r_finished   <= n_finished;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_pixel <= n_out_pixel;
        r_out_count <= n_out_count;
        r_out_done  <= n_out_done;
        r_out_over  <= n_out_over;
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_value  = r_out_pixel;
    assign o_repeat_count = r_out_count;
    assign o_image_done   = r_out_done;
    assign o_overrun      = r_out_over;

endmodule
